/* design/imc_pkg.sv */
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types, status codes and the mod 97 reduction used by the IBAN
// check digit core.
// ----------------------------------------------------------------------------
`default_nettype none

package imc_pkg;

  localparam int unsigned REM_W         = 7;   // remainder mod 97
  localparam int unsigned RAW_W         = 3;   // raw character count, saturating
  localparam int unsigned DIGIT_W       = 9;   // body digit count
  localparam int unsigned PLEN_W        = 4;   // held prefix digits, at most 8
  localparam int unsigned ST_W          = 3;
  localparam int unsigned RED_W         = 14;  // widest value fed to the reducer
  localparam int unsigned RAW_SAT       = 5;
  localparam int unsigned PREFIX_CHARS  = 4;
  localparam int unsigned COUNTRY_CHARS = 2;
  localparam int unsigned MOD           = 97;

  localparam logic [ST_W-1:0] ST_VALID   = 3'd0;
  localparam logic [ST_W-1:0] ST_BADSUM  = 3'd1;
  localparam logic [ST_W-1:0] ST_SHORT   = 3'd2;
  localparam logic [ST_W-1:0] ST_COUNTRY = 3'd3;
  localparam logic [ST_W-1:0] ST_BADCHAR = 3'd4;
  localparam logic [ST_W-1:0] ST_LONG    = 3'd5;

  typedef enum logic [1:0] {
    KIND_SPACE,
    KIND_LETTER,
    KIND_DIGIT,
    KIND_BAD
  } kind_t;

  // one classified character
  typedef struct packed {
    kind_t      kind;
    logic [5:0] val;    // 10..35 for a letter, 0..9 for a digit
    logic       upper;  // raw byte is A..Z, no case folding
    logic       last;
  } item_t;

  // x mod 97 for x below 2**14: reciprocal estimate is low by at most one
  function automatic logic [REM_W-1:0] mod97(input logic [RED_W-1:0] x);
    logic [25:0] est;
    logic [7:0]  q;
    logic [14:0] r;
    est = 26'(x) * 26'd2702;
    q   = est[25:18];
    r   = 15'(x) - 15'(q) * 15'(MOD);
    if (r >= 15'(MOD)) begin
      r = r - 15'(MOD);
    end
    return r[REM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/imc_fifo.sv */
// ----------------------------------------------------------------------------
// imc_fifo
// Small synchronous queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module imc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* design/imc_front.sv */
// ----------------------------------------------------------------------------
// imc_front
// Character classifier: folds lowercase, maps letters to 10..35 and digits
// to 0..9, flags spaces and bad bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module imc_front (
  input  wire logic [7:0]     ch,
  input  wire logic           last,
  output imc_pkg::item_t      item
);

  logic [7:0] up;

  always_comb begin
    up = ch;
    if (ch inside {[8'h61:8'h7a]}) begin
      up = ch - 8'h20;
    end
    item.last  = last;
    item.upper = (ch inside {[8'h41:8'h5a]});
    item.val   = '0;
    if (up == 8'h20) begin
      item.kind = imc_pkg::KIND_SPACE;
    end else if (up inside {[8'h41:8'h5a]}) begin
      item.kind = imc_pkg::KIND_LETTER;
      item.val  = 6'(up - 8'h41) + 6'd10;
    end else if (up inside {[8'h30:8'h39]}) begin
      item.kind = imc_pkg::KIND_DIGIT;
      item.val  = 6'(up - 8'h30);
    end else begin
      item.kind = imc_pkg::KIND_BAD;
    end
  end

endmodule

`default_nettype wire

/* design/imc_back.sv */
// ----------------------------------------------------------------------------
// imc_back
// Running mod 97 state per IBAN and a two stage finish pipeline that
// appends the held prefix and forms the status.
// ----------------------------------------------------------------------------
`default_nettype none

module imc_back #(
  parameter int unsigned MAX_DIGITS = 255,
  parameter int unsigned OUT_DEPTH  = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire imc_pkg::item_t                     item,
  input  wire logic                               item_empty,
  output logic                                    item_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                                    res_valid,
  output logic      [imc_pkg::ST_W-1:0]           res_status
);

  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned REM_W = imc_pkg::REM_W;

  // running state
  logic [REM_W-1:0]            rem_r, rem_nxt, rem_upd;
  logic [REM_W-1:0]            pre_r, pre_nxt, pre_upd;   // prefix value mod 97
  logic [REM_W-1:0]            pow_r, pow_nxt, pow_upd;   // 10**prefix_len mod 97
  logic [imc_pkg::RAW_W-1:0]   raw_r, raw_nxt, raw_upd;
  logic [imc_pkg::DIGIT_W-1:0] dc_r, dc_nxt, dc_upd;
  logic [imc_pkg::PLEN_W-1:0]  plen_r, plen_nxt, plen_upd;
  logic [imc_pkg::ST_W-1:0]    ferr_r, ferr_nxt, ferr_upd;
  logic                        pbad_r, pbad_nxt, pbad_upd;

  // finish pipeline
  logic                            rec_vld_r;
  logic [REM_W-1:0]                rec_rem_r, rec_pow_r, rec_pre_r;
  logic [imc_pkg::ST_W-1:0]        rec_code_r, fin_code;
  logic                            rec_sum_r, fin_sum;
  logic                            prd_vld_r;
  logic [imc_pkg::RED_W-1:0]       prd_val_r;
  logic [imc_pkg::ST_W-1:0]        prd_code_r;
  logic                            prd_sum_r;

  logic                            room;
  logic                            take;
  logic [9:0]                      need;

  // a closing item needs a slot for itself and for results still in flight
  assign room = (CNT_W+1)'(out_count) + (CNT_W+1)'(rec_vld_r) + (CNT_W+1)'(prd_vld_r)
                < (CNT_W+1)'(OUT_DEPTH);
  assign take     = !item_empty && (!item.last || room);
  assign item_pop = take;

  always_comb begin
    rem_upd  = rem_r;
    pre_upd  = pre_r;
    pow_upd  = pow_r;
    dc_upd   = dc_r;
    plen_upd = plen_r;
    ferr_upd = ferr_r;
    pbad_upd = pbad_r;
    raw_upd  = (raw_r < imc_pkg::RAW_W'(imc_pkg::RAW_SAT)) ? raw_r + 1'b1 : raw_r;
    need     = (item.kind == imc_pkg::KIND_LETTER) ? 10'd2 : 10'd1;

    if (raw_r < imc_pkg::RAW_W'(imc_pkg::PREFIX_CHARS)) begin
      if (raw_r < imc_pkg::RAW_W'(imc_pkg::COUNTRY_CHARS) && !item.upper &&
          ferr_r == imc_pkg::ST_VALID) begin
        ferr_upd = imc_pkg::ST_COUNTRY;
      end
      if (!pbad_r) begin
        case (item.kind)
          imc_pkg::KIND_LETTER: begin
            pre_upd  = imc_pkg::mod97(14'(pre_r) * 14'd100 + 14'(item.val));
            pow_upd  = imc_pkg::mod97(14'(pow_r) * 14'd100);
            plen_upd = plen_r + 4'd2;
          end
          imc_pkg::KIND_DIGIT: begin
            pre_upd  = imc_pkg::mod97(14'(pre_r) * 14'd10 + 14'(item.val));
            pow_upd  = imc_pkg::mod97(14'(pow_r) * 14'd10);
            plen_upd = plen_r + 4'd1;
          end
          imc_pkg::KIND_BAD: pbad_upd = 1'b1;
          default: ;
        endcase
      end
    end else if (ferr_r == imc_pkg::ST_VALID) begin
      case (item.kind)
        imc_pkg::KIND_LETTER, imc_pkg::KIND_DIGIT: begin
          if (10'(dc_r) + need > 10'(MAX_DIGITS)) begin
            ferr_upd = imc_pkg::ST_LONG;
          end else begin
            dc_upd = dc_r + imc_pkg::DIGIT_W'(need);
            if (item.kind == imc_pkg::KIND_LETTER) begin
              rem_upd = imc_pkg::mod97(14'(rem_r) * 14'd100 + 14'(item.val));
            end else begin
              rem_upd = imc_pkg::mod97(14'(rem_r) * 14'd10 + 14'(item.val));
            end
          end
        end
        imc_pkg::KIND_BAD: ferr_upd = imc_pkg::ST_BADCHAR;
        default: ;
      endcase
    end

    // status decided without the checksum, or checksum needed
    fin_sum  = 1'b0;
    fin_code = imc_pkg::ST_VALID;
    if (raw_upd < imc_pkg::RAW_W'(imc_pkg::RAW_SAT)) begin
      fin_code = imc_pkg::ST_SHORT;
    end else if (ferr_upd != imc_pkg::ST_VALID) begin
      fin_code = ferr_upd;
    end else if (10'(dc_upd) + 10'(plen_upd) > 10'(MAX_DIGITS)) begin
      fin_code = imc_pkg::ST_LONG;
    end else if (pbad_upd) begin
      fin_code = imc_pkg::ST_BADCHAR;
    end else begin
      fin_sum = 1'b1;
    end

    rem_nxt  = rem_r;
    pre_nxt  = pre_r;
    pow_nxt  = pow_r;
    raw_nxt  = raw_r;
    dc_nxt   = dc_r;
    plen_nxt = plen_r;
    ferr_nxt = ferr_r;
    pbad_nxt = pbad_r;
    if (take) begin
      if (item.last) begin
        rem_nxt  = '0;
        pre_nxt  = '0;
        pow_nxt  = REM_W'(1);
        raw_nxt  = '0;
        dc_nxt   = '0;
        plen_nxt = '0;
        ferr_nxt = imc_pkg::ST_VALID;
        pbad_nxt = 1'b0;
      end else begin
        rem_nxt  = rem_upd;
        pre_nxt  = pre_upd;
        pow_nxt  = pow_upd;
        raw_nxt  = raw_upd;
        dc_nxt   = dc_upd;
        plen_nxt = plen_upd;
        ferr_nxt = ferr_upd;
        pbad_nxt = pbad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      pre_r     <= '0;
      pow_r     <= REM_W'(1);
      raw_r     <= '0;
      dc_r      <= '0;
      plen_r    <= '0;
      ferr_r    <= imc_pkg::ST_VALID;
      pbad_r    <= 1'b0;
      rec_vld_r <= 1'b0;
      prd_vld_r <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      pre_r     <= pre_nxt;
      pow_r     <= pow_nxt;
      raw_r     <= raw_nxt;
      dc_r      <= dc_nxt;
      plen_r    <= plen_nxt;
      ferr_r    <= ferr_nxt;
      pbad_r    <= pbad_nxt;
      rec_vld_r <= take && item.last;
      prd_vld_r <= rec_vld_r;
    end
  end

  // payload of the finish pipeline
  always_ff @(posedge clk) begin
    rec_rem_r  <= rem_upd;
    rec_pow_r  <= pow_upd;
    rec_pre_r  <= pre_upd;
    rec_code_r <= fin_code;
    rec_sum_r  <= fin_sum;
    // body remainder shifted past the prefix digits, then the prefix added
    prd_val_r  <= 14'(rec_rem_r) * 14'(rec_pow_r) + 14'(rec_pre_r);
    prd_code_r <= rec_code_r;
    prd_sum_r  <= rec_sum_r;
  end

  assign res_valid = prd_vld_r;

  always_comb begin
    res_status = prd_code_r;
    if (prd_sum_r) begin
      res_status = (imc_pkg::mod97(prd_val_r) == REM_W'(1)) ? imc_pkg::ST_VALID
                                                            : imc_pkg::ST_BADSUM;
    end
  end

endmodule

`default_nettype wire

/* design/iban_mod97_check_core.sv */
// ----------------------------------------------------------------------------
// iban_mod97_check_core
// IBAN check digit verifier, one character per item, mod 97-10.
// ----------------------------------------------------------------------------
// Input queue: drive in_ch/in_last and raise in_push; the item is taken on a
// clock edge where in_full is low. in_last marks the final character of one
// IBAN and closes it; every IBAN yields exactly one status item.
// Result queue: out_status is valid while out_empty is low and is consumed
// by out_pop. Codes: 0 valid, 1 bad checksum, 2 too short, 3 country not
// uppercase, 4 bad char, 5 too long.
// Throughput is one character per cycle while the back end is not holding a
// closing character. A character is classified on entry, buffered in a short
// queue and folded into the running remainder by the back end; a closing
// character then passes two finish stages (state capture, prefix shift by
// multiply) and a final reduction before its status enters the result queue.
// When out_pop stays low the result queue fills, the back end holds closing
// characters, the character queue fills and in_full rises.
// Reset clears both queues and the running state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module iban_mod97_check_core #(
  parameter int unsigned MAX_DIGITS = 255,
  parameter int unsigned MID_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH  = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  input  wire logic [7:0]               in_ch,
  input  wire logic                     in_last,
  output logic                          in_full,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic [imc_pkg::ST_W-1:0]      out_status
);

  localparam int unsigned ITEM_W = $bits(imc_pkg::item_t);

  imc_pkg::item_t                   cls_item;
  logic [ITEM_W-1:0]                mid_rdata;
  imc_pkg::item_t                   mid_item;
  logic                             mid_empty;
  logic                             mid_pop;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
  logic                             out_full;
  logic                             res_valid;
  logic [imc_pkg::ST_W-1:0]         res_status;

  assign mid_item = imc_pkg::item_t'(mid_rdata);

  imc_front u_front (
    .ch   (in_ch),
    .last (in_last),
    .item (cls_item)
  );

  imc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls_item),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (in_full),
    .empty (mid_empty),
    .count ()
  );

  imc_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (mid_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .out_count  (out_count),
    .res_valid  (res_valid),
    .res_status (res_status)
  );

  imc_fifo #(
    .WIDTH (imc_pkg::ST_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res_status),
    .pop   (out_pop),
    .rdata (out_status),
    .full  (out_full),
    .empty (out_empty),
    .count (out_count)
  );

`ifndef SYNTHESIS
  // results in flight always find a free slot
  a_no_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_full)
    else $error("result written into a full result queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end took a character from an empty queue");

  // a result follows every taken closing character through the rec and prd registers
  a_res_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop && mid_item.last) |-> ##2 res_valid)
    else $error("closing character produced no result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_status <= imc_pkg::ST_LONG))
    else $error("status code out of range");
`endif

endmodule

`default_nettype wire
